@@ rtl/hpid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared widths, register codes, status codes and stage types for the
// heading pid turn controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

  localparam int unsigned HEADING_W  = 18;
  localparam int unsigned ERR_W      = 19;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned DERIV_W    = 20;
  localparam int unsigned COUNT_W    = 20;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 17;
  localparam int unsigned BAND_W     = 12;
  localparam int unsigned BACKOFF_W  = 15;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned P_KP_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned P_KI_W = GAIN_W + 1 + SUM_W;
  localparam int unsigned P_KD_W = GAIN_W + 1 + DERIV_W;
  localparam int unsigned ACC_W  = P_KD_W + 2;

  // 180 and 360 degrees in 1/256 degree
  localparam logic signed [20:0] WRAP_HALF = 21'sd46080;
  localparam logic signed [20:0] WRAP_FULL = 21'sd92160;
  localparam logic signed [20:0] ERR_POS   = 21'sd262143;
  localparam logic signed [20:0] ERR_NEG   = -21'sd262144;

  localparam logic [CFG_IDX_W-1:0] CFG_TURN_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BAND     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_DRIVE = 3'd7;

  localparam logic [GAIN_W-1:0]    KP_RESET      = 16'd6554;
  localparam logic [GAIN_W-1:0]    KI_RESET      = 16'd66;
  localparam logic [GAIN_W-1:0]    KD_RESET      = 16'd328;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 17'd25600;
  localparam logic [BAND_W-1:0]    BAND_RESET    = 12'd256;
  localparam logic [COUNT_W-1:0]   TIMEOUT_RESET = 20'd3000;
  localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = 15'd5120;

  typedef enum logic [1:0] {
    STATUS_TURNING = 2'd0,
    STATUS_REACHED = 2'd1,
    STATUS_TIMEOUT = 2'd2,
    STATUS_IDLE    = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [HEADING_W-1:0] turn_target;
    logic [GAIN_W-1:0]           kp_gain;
    logic [GAIN_W-1:0]           ki_gain;
    logic [GAIN_W-1:0]           kd_gain;
    logic [LIMIT_W-1:0]          integral_limit;
    logic [BAND_W-1:0]           stop_band;
    logic [COUNT_W-1:0]          timeout_samples;
    logic [BACKOFF_W-1:0]        backoff_drive;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    status_e                   status;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   esum;
    logic signed [DERIV_W-1:0] deriv;
  } errs_t;

  typedef struct packed {
    logic                     valid;
    status_e                  status;
    logic signed [P_KP_W-1:0] p_kp;
    logic signed [P_KI_W-1:0] p_ki;
    logic signed [P_KD_W-1:0] p_kd;
  } prod_t;

endpackage

@@ rtl/hpid_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module hpid_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hpid_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hpid_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output hpid_pkg::cfg_t                   cfg_o
);
  import hpid_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_target     <= '0;
      cfg_q.kp_gain         <= KP_RESET;
      cfg_q.ki_gain         <= KI_RESET;
      cfg_q.kd_gain         <= KD_RESET;
      cfg_q.integral_limit  <= LIMIT_RESET;
      cfg_q.stop_band       <= BAND_RESET;
      cfg_q.timeout_samples <= TIMEOUT_RESET;
      cfg_q.backoff_drive   <= BACKOFF_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TURN_TARGET:   cfg_q.turn_target     <= cfg_data_i[HEADING_W-1:0];
        CFG_KP_GAIN:       cfg_q.kp_gain         <= cfg_data_i[GAIN_W-1:0];
        CFG_KI_GAIN:       cfg_q.ki_gain         <= cfg_data_i[GAIN_W-1:0];
        CFG_KD_GAIN:       cfg_q.kd_gain         <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEGRAL_LIM:  cfg_q.integral_limit  <= cfg_data_i[LIMIT_W-1:0];
        CFG_STOP_BAND:     cfg_q.stop_band       <= cfg_data_i[BAND_W-1:0];
        CFG_TIMEOUT:       cfg_q.timeout_samples <= cfg_data_i[COUNT_W-1:0];
        CFG_BACKOFF_DRIVE: cfg_q.backoff_drive   <= cfg_data_i[BACKOFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/hpid_error_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_error_stage
// Holds the turn state; forms the wrapped error, clamped integral,
// difference term and step status for each sample.
// ----------------------------------------------------------------------------
module hpid_error_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [hpid_pkg::HEADING_W-1:0] heading_i,
  input  logic                                start_i,
  input  hpid_pkg::cfg_t                      cfg_i,
  output hpid_pkg::errs_t                     errs_o
);
  import hpid_pkg::*;

  logic signed [HEADING_W-1:0] init_q;
  logic signed [SUM_W-1:0]     esum_q;
  logic signed [ERR_W-1:0]     last_q;
  logic [COUNT_W-1:0]          count_q;
  logic                        turning_q;

  logic signed [HEADING_W-1:0] init_eff;
  logic signed [SUM_W-1:0]     esum_eff;
  logic signed [ERR_W-1:0]     last_eff;
  logic [COUNT_W-1:0]          count_eff;
  logic                        turning_eff;

  logic signed [HEADING_W:0]   diff;
  logic signed [20:0]          raw;
  logic signed [20:0]          wrapped;
  logic signed [ERR_W-1:0]     err;
  logic [ERR_W-1:0]            mag;
  logic                        reached;
  logic signed [SUM_W+1:0]     sum_raw;
  logic signed [SUM_W+1:0]     lim;
  logic signed [SUM_W-1:0]     esum_new;
  logic signed [DERIV_W-1:0]   deriv;
  logic [COUNT_W-1:0]          count_inc;
  logic                        timeout;
  status_e                     status;
  logic                        step;

  errs_t errs_q;

  always_comb begin
    init_eff    = start_i ? heading_i : init_q;
    esum_eff    = start_i ? '0 : esum_q;
    last_eff    = start_i ? '0 : last_q;
    count_eff   = start_i ? '0 : count_q;
    turning_eff = start_i | turning_q;

    diff = {heading_i[HEADING_W-1], heading_i} - {init_eff[HEADING_W-1], init_eff};
    raw  = {{3{cfg_i.turn_target[HEADING_W-1]}}, cfg_i.turn_target}
         - {{2{diff[HEADING_W]}}, diff};
    if (raw < -WRAP_HALF) begin
      wrapped = raw + WRAP_FULL;
    end else if (raw > WRAP_HALF) begin
      wrapped = raw - WRAP_FULL;
    end else begin
      wrapped = raw;
    end
    if (wrapped > ERR_POS) begin
      err = ERR_POS[ERR_W-1:0];
    end else if (wrapped < ERR_NEG) begin
      err = ERR_NEG[ERR_W-1:0];
    end else begin
      err = wrapped[ERR_W-1:0];
    end

    mag     = err[ERR_W-1] ? (~err + 1'b1) : err;
    reached = mag < {{(ERR_W-BAND_W){1'b0}}, cfg_i.stop_band};

    sum_raw = {{2{esum_eff[SUM_W-1]}}, esum_eff} + {err[ERR_W-1], err};
    lim     = {{(SUM_W+2-LIMIT_W){1'b0}}, cfg_i.integral_limit};
    if (sum_raw > lim) begin
      esum_new = lim[SUM_W-1:0];
    end else if (sum_raw < -lim) begin
      esum_new = SUM_W'(-lim);
    end else begin
      esum_new = sum_raw[SUM_W-1:0];
    end

    deriv = {err[ERR_W-1], err} - {last_eff[ERR_W-1], last_eff};

    count_inc = (&count_eff) ? count_eff : count_eff + 1'b1;
    timeout   = count_inc >= cfg_i.timeout_samples;

    if (!turning_eff) begin
      status = STATUS_IDLE;
    end else if (reached) begin
      status = STATUS_REACHED;
    end else if (timeout) begin
      status = STATUS_TIMEOUT;
    end else begin
      status = STATUS_TURNING;
    end

    step = turning_eff & ~reached;
  end

  // turn state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      esum_q    <= '0;
      last_q    <= '0;
      count_q   <= '0;
      turning_q <= 1'b0;
    end else if (en_i && valid_i) begin
      init_q    <= init_eff;
      turning_q <= step & ~timeout;
      if (step) begin
        esum_q  <= esum_new;
        last_q  <= err;
        count_q <= count_inc;
      end else begin
        esum_q  <= esum_eff;
        last_q  <= last_eff;
        count_q <= count_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errs_q <= '0;
    end else if (en_i) begin
      errs_q.valid <= valid_i;
      if (valid_i) begin
        errs_q.status <= status;
        errs_q.err    <= err;
        errs_q.esum   <= esum_new;
        errs_q.deriv  <= deriv;
      end
    end
  end

  assign errs_o = errs_q;

endmodule

@@ rtl/hpid_mult_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_mult_stage
// Applies the three gains to error, integral and difference, one
// registered product each.
// ----------------------------------------------------------------------------
module hpid_mult_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  hpid_pkg::errs_t errs_i,
  input  hpid_pkg::cfg_t  cfg_i,
  output hpid_pkg::prod_t prod_o
);
  import hpid_pkg::*;

  logic signed [P_KP_W-1:0] p_kp_d;
  logic signed [P_KI_W-1:0] p_ki_d;
  logic signed [P_KD_W-1:0] p_kd_d;
  prod_t                    prod_q;

  always_comb begin
    p_kp_d = $signed({1'b0, cfg_i.kp_gain}) * errs_i.err;
    p_ki_d = $signed({1'b0, cfg_i.ki_gain}) * errs_i.esum;
    p_kd_d = $signed({1'b0, cfg_i.kd_gain}) * errs_i.deriv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (en_i) begin
      prod_q.valid <= errs_i.valid;
      if (errs_i.valid) begin
        prod_q.status <= errs_i.status;
        prod_q.p_kp   <= p_kp_d;
        prod_q.p_ki   <= p_ki_d;
        prod_q.p_kd   <= p_kd_d;
      end
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/hpid_drive_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpid_drive_stage
// Sums the products, rounds and saturates the drive, and steers it to
// the wheels into the result register.
// ----------------------------------------------------------------------------
module hpid_drive_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  hpid_pkg::prod_t                     prod_i,
  input  hpid_pkg::cfg_t                      cfg_i,
  output logic                                valid_o,
  output logic signed [hpid_pkg::DRIVE_W-1:0] left_drive_o,
  output logic signed [hpid_pkg::DRIVE_W-1:0] right_drive_o,
  output logic [1:0]                          turn_status_o
);
  import hpid_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
  localparam int unsigned             RND_W      = ACC_W - 16;
  localparam logic signed [RND_W-1:0] DRV_POS    = RND_W'(32767);
  localparam logic signed [RND_W-1:0] DRV_NEG    = -RND_W'(32768);

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [RND_W-1:0]   rnd;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [DRIVE_W-1:0] backoff;
  logic signed [DRIVE_W-1:0] left_d;
  logic signed [DRIVE_W-1:0] right_d;

  logic                      valid_q;
  logic signed [DRIVE_W-1:0] left_q;
  logic signed [DRIVE_W-1:0] right_q;
  status_e                   status_q;

  always_comb begin
    acc = ACC_W'(prod_i.p_kp) + ACC_W'(prod_i.p_ki) + ACC_W'(prod_i.p_kd);
    acc_rnd = acc + ROUND_HALF;
    rnd     = acc_rnd[ACC_W-1:16];
    if (rnd > DRV_POS) begin
      drive = DRV_POS[DRIVE_W-1:0];
    end else if (rnd < DRV_NEG) begin
      drive = DRV_NEG[DRIVE_W-1:0];
    end else begin
      drive = rnd[DRIVE_W-1:0];
    end
    backoff = DRIVE_W'(-$signed({1'b0, cfg_i.backoff_drive}));

    left_d  = '0;
    right_d = '0;
    case (prod_i.status)
      STATUS_TIMEOUT: begin
        left_d  = backoff;
        right_d = backoff;
      end
      STATUS_TURNING: begin
        if (drive[DRIVE_W-1]) begin
          // most negative drive gives full forward right wheel
          right_d = (drive == DRV_NEG[DRIVE_W-1:0]) ? DRV_POS[DRIVE_W-1:0] : -drive;
        end else begin
          left_d = drive;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prod_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && prod_i.valid) begin
      left_q   <= left_d;
      right_q  <= right_d;
      status_q <= prod_i.status;
    end
  end

  assign valid_o       = valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign turn_status_o = status_q;

endmodule

@@ rtl/heading_pid_turn_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_turn_controller
// PID turn controller on heading samples with integral clamp, stop band
// and sample-count timeout.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one heading sample per request; start_req_i begins a new
//   turn from that sample. One result per sample leaves on the out
//   channel: left and right wheel drive and turn status.
//   cfg channel: register index and data, always ready; write only while
//   no sample is in flight.
// Path: sample register, error, gain and drive stages to the result;
//   a sample that came in during a stall waits in the skid register first.
// Throughput: one sample per cycle unless a result stalls; the turn
//   state (integral, previous error, count) is updated in the error
//   stage, and the gain products and drive sum follow in two further stages.
// Reset: registers with a reset value return to it, the turn is idle and
//   the pipeline is empty.
// Stall: a stalled result holds and the pipeline freezes; the skid
//   register takes one further sample, then in_stall_o rises.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [hpid_pkg::HEADING_W-1:0] heading_i,
  input  logic                                  start_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hpid_pkg::DRIVE_W-1:0]   left_drive_o,
  output logic signed [hpid_pkg::DRIVE_W-1:0]   right_drive_o,
  output logic [1:0]                            turn_status_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hpid_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hpid_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import hpid_pkg::*;

  cfg_t  cfg;
  errs_t errs;
  prod_t prod;
  logic  en;
  logic  in_acc;

  logic                        skid_valid_q;
  logic signed [HEADING_W-1:0] skid_heading_q;
  logic                        skid_start_q;
  logic                        s0_valid_q;
  logic signed [HEADING_W-1:0] s0_heading_q;
  logic                        s0_start_q;

  assign en         = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;

  // input skid and sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      s0_valid_q   <= 1'b0;
    end else if (en) begin
      s0_valid_q   <= skid_valid_q | in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_heading_q <= skid_valid_q ? skid_heading_q : heading_i;
      s0_start_q   <= skid_valid_q ? skid_start_q : start_req_i;
    end else if (in_acc) begin
      skid_heading_q <= heading_i;
      skid_start_q   <= start_req_i;
    end
  end

  hpid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hpid_error_stage u_err (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s0_valid_q),
    .heading_i (s0_heading_q),
    .start_i   (s0_start_q),
    .cfg_i     (cfg),
    .errs_o    (errs)
  );

  hpid_mult_stage u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .errs_i (errs),
    .cfg_i  (cfg),
    .prod_o (prod)
  );

  hpid_drive_stage u_drive (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .prod_i        (prod),
    .cfg_i         (cfg),
    .valid_o       (out_valid_o),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .turn_status_o (turn_status_o)
  );

`ifndef ASSERT_OFF
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && en |=> !skid_valid_q)
    else $error("skid register not drained");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_valid_q && !$past(skid_valid_q) ##1 skid_valid_q |-> !$past(en))
    else $error("skid filled while pipeline moving");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (turn_status_o == STATUS_IDLE || turn_status_o == STATUS_REACHED)
    |-> left_drive_o == '0 && right_drive_o == '0)
    else $error("drive on idle or reached result");

  a_turning_one_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && turn_status_o == STATUS_TURNING
    |-> (left_drive_o == '0 || right_drive_o == '0)
        && !left_drive_o[DRIVE_W-1] && !right_drive_o[DRIVE_W-1])
    else $error("turning result drives both wheels or reverse");

  a_timeout_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && turn_status_o == STATUS_TIMEOUT
    |-> left_drive_o == right_drive_o && !left_drive_o[DRIVE_W-1] == (left_drive_o == '0))
    else $error("timeout backoff drive mismatch");
`endif

endmodule
